// ----- sv/u8250_pkg.sv -----
// ----------------------------------------------------------------------------
// u8250_pkg
// Shared types and constants for the 8250/16450 register model core.
// ----------------------------------------------------------------------------
package u8250_pkg;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_RXIN  = 3'd2;
  localparam logic [2:0] CMD_TXOUT = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_MODEM = 3'd5;
  localparam logic [2:0] CMD_RSV6  = 3'd6;
  localparam logic [2:0] CMD_RSV7  = 3'd7;

  localparam logic [2:0] CFG_SCRATCH = 3'd0;
  localparam logic [2:0] CFG_BITDIV  = 3'd1;
  localparam logic [2:0] CFG_RBURST  = 3'd2;
  localparam logic [2:0] CFG_WBURST  = 3'd3;
  localparam logic [2:0] CFG_RSLOTS  = 3'd4;
  localparam logic [2:0] CFG_TSLOTS  = 3'd5;

  // bus register offsets
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_THRE = 8'h02;
  localparam logic [7:0] IIR_RDA  = 8'h04;

  localparam logic [7:0] LSR_DR   = 8'h01;
  localparam logic [7:0] LSR_THRE = 8'h20;
  localparam logic [7:0] LSR_TEMT = 8'h40;

  localparam logic [31:0] CHAR_TIME_RST = 32'd128;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] tx_byte;
    logic       refused;
  } result_t;

endpackage

// ----- sv/uart_8250_register_model_core.sv -----
// A tick that expires both pacing counters in loopback walks the longest path.
// One command at a time: a new command is accepted only after the result of
//   the last is taken; ring reads are registered, and the char-time multiply
//   runs through S_MUL1 and S_MUL2.
// Reset: synchronous, active high; rings empty, registers at 8250 defaults.
// Ring contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// uart_8250_register_model_core
// 8250/16450 register file with receive and transmit rings in RAM.
// ----------------------------------------------------------------------------
module uart_8250_register_model_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [2:0]  reg_addr,
  input  logic [7:0]  data_in,
  input  logic [15:0] tick_count,
  input  logic        dsr_in,
  input  logic        cts_in,
  input  logic        dcd_in,
  input  logic        ri_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [7:0]  tx_byte,
  output logic        refused,
  output logic        irq_line,
  output logic        dtr_out,
  output logic        rts_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import u8250_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SW-1:0] QD = SW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_FILLR = 4'd2;  // rx ring read issued for fill
  localparam logic [3:0] S_FILLD = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_TXRD  = 4'd5;
  localparam logic [3:0] S_TXD   = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_IRQ   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_TICKT = 4'd11;

  logic [3:0] state;

  // configuration
  logic       has_scratch;
  logic [7:0] bit_clock_divider, read_burst_max, write_burst_max;
  logic [SW-1:0] rx_slots, tx_slots;

  // architectural state
  logic [AW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [7:0] rx_holding, tx_holding, line_control, line_status, modem_status;
  logic [7:0] int_ident, scratch_byte, rx_burst_left, tx_burst_left;
  logic [3:0] int_enable;
  logic [4:0] modem_control;
  logic       tx_empty_acked, pacing_active, irq_level;
  logic [31:0] rx_time_left, tx_time_left, char_time;
  logic [15:0] baud_divisor;

  // item latch and result
  logic [2:0]  cmd;
  logic [2:0]  addr;
  logic [7:0]  dat;
  logic [15:0] tck;
  logic [3:0]  lines;
  result_t     res;
  logic        tick_tx;           // tick must handle tx after rx
  logic [15:0] mul_a;
  logic [31:0] mul_p;

  // ring memories
  logic          rx_we, tx_we;
  logic [AW-1:0] rx_wa, tx_wa, rx_ra, tx_ra;
  logic [7:0]    rx_wd, tx_wd, rx_rd, tx_rd;

  u8250_ram #(.Width(8), .Depth(QUEUE_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_wa), .wdata(rx_wd), .raddr(rx_ra), .rdata(rx_rd)
  );
  u8250_ram #(.Width(8), .Depth(QUEUE_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_wa), .wdata(tx_wd), .raddr(tx_ra), .rdata(tx_rd)
  );

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i, input logic [SW-1:0] n);
    logic [SW:0] s;
    s = {1'b0, SW'(i)} + 1'b1;
    return (s < {1'b0, n}) ? AW'(s) : '0;
  endfunction

  function automatic logic [SW-1:0] clamp(input logic [4:0] v);
    logic [SW-1:0] r;
    if (v == 5'd0) r = SW'(1);
    else if ({27'd0, v} > QUEUE_DEPTH) r = QD;
    else r = SW'(v);
    return r;
  endfunction

  function automatic logic [7:0] set_ln(input logic [7:0] old, input logic [7:0] ln);
    logic [7:0] now, chg;
    now = (old & 8'h0f) | (ln & 8'hf0);
    chg = ((old ^ now) & ~(now & 8'h40)) & 8'hf0;
    return now | {4'd0, chg[7:4]};
  endfunction

  // combinational views
  logic rx_full_c, rx_empty_c, tx_full_c, tx_empty_c, loop_c, dlab;
  assign rx_full_c  = nxt(rx_tail, rx_slots) == rx_head;
  assign rx_empty_c = rx_head == rx_tail;
  assign tx_full_c  = nxt(tx_tail, tx_slots) == tx_head;
  assign tx_empty_c = tx_head == tx_tail;
  assign loop_c     = modem_control[4];
  assign dlab       = line_control[7];

  logic can_fill;
  assign can_fill = rx_burst_left != 8'd0 && !line_status[0] && !rx_empty_c;

  logic [3:0] char_bits;
  assign char_bits = 4'd6 + {2'b0, line_control[1:0]} + (line_control[2] ? 4'd2 : 4'd1);

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign read_data = res.read_data;
  assign tx_byte   = res.tx_byte;
  assign refused   = res.refused;
  assign irq_line  = irq_level;
  assign dtr_out   = modem_control[0];
  assign rts_out   = modem_control[1];

  // ring memory ports
  always_comb begin
    rx_we = 1'b0; rx_wa = rx_tail; rx_wd = dat;
    tx_we = 1'b0; tx_wa = tx_tail; tx_wd = tx_holding;
    rx_ra = rx_head; tx_ra = tx_head;
    if (state == S_EXEC && cmd == CMD_RXIN && !rx_full_c) rx_we = 1'b1;
    if (state == S_DRAIN && tx_burst_left != 8'd0 && !line_status[5]) begin
      if (loop_c) begin
        rx_we = !rx_full_c;
        rx_wd = tx_holding;
      end else begin
        tx_we = !tx_full_c;
      end
    end
  end

  // sequencer and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      has_scratch <= 1'b1; bit_clock_divider <= 8'd10;
      read_burst_max <= 8'd1; write_burst_max <= 8'd1;
      rx_slots <= clamp(5'd9); tx_slots <= clamp(5'd9);
      rx_head <= '0; rx_tail <= '0; tx_head <= '0; tx_tail <= '0;
      rx_holding <= '0; tx_holding <= '0; int_enable <= '0; int_ident <= IIR_NONE;
      line_control <= '0; line_status <= 8'h60; modem_control <= '0;
      modem_status <= '0; tx_empty_acked <= 1'b1; pacing_active <= 1'b0;
      rx_time_left <= '0; tx_time_left <= '0; char_time <= CHAR_TIME_RST;
      rx_burst_left <= 8'd1; tx_burst_left <= 8'd1; baud_divisor <= '0;
      scratch_byte <= '0; irq_level <= 1'b0;
      tick_tx <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCRATCH: has_scratch <= cfg_data[0];
          CFG_BITDIV:  bit_clock_divider <= cfg_data;
          CFG_RBURST:  read_burst_max <= cfg_data;
          CFG_WBURST:  write_burst_max <= cfg_data;
          CFG_RSLOTS: begin
            rx_slots <= clamp(cfg_data[4:0]); rx_head <= '0; rx_tail <= '0;
          end
          CFG_TSLOTS: begin
            tx_slots <= clamp(cfg_data[4:0]); tx_head <= '0; tx_tail <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command; addr <= reg_addr; dat <= data_in; tck <= tick_count;
            lines <= {dcd_in, ri_in, dsr_in, cts_in};
            res <= '0;
            tick_tx <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IRQ;
          unique case (cmd)
            CMD_READ: begin
              unique case (addr)
                REG_DATA: if (dlab) res.read_data <= baud_divisor[7:0];
                      else begin
                        res.read_data <= rx_holding;
                        line_status <= line_status & ~LSR_DR;
                        state <= S_FILLR;
                      end
                REG_IER: res.read_data <= dlab ? baud_divisor[15:8] : {4'd0, int_enable};
                REG_IIR: begin
                  res.read_data <= int_ident;
                  if (int_ident == IIR_THRE) tx_empty_acked <= 1'b1;
                end
                REG_LCR: res.read_data <= line_control;
                REG_MCR: res.read_data <= {3'd0, modem_control};
                REG_LSR: res.read_data <= line_status;
                REG_MSR: begin
                  res.read_data <= modem_status;
                  modem_status <= modem_status & 8'hf0;
                end
                default: res.read_data <= has_scratch ? scratch_byte : 8'hff;
              endcase
            end
            CMD_WRITE: begin
              unique case (addr)
                REG_DATA: if (dlab) begin
                        baud_divisor[7:0] <= dat; state <= S_MUL1;
                      end else begin
                        tx_holding <= dat;
                        line_status <= line_status & ~LSR_THRE;
                        state <= S_DRAIN;
                      end
                REG_IER: if (dlab) begin
                        baud_divisor[15:8] <= dat; state <= S_MUL1;
                      end else begin
                        int_enable <= dat[3:0]; tx_empty_acked <= 1'b0;
                      end
                REG_LCR: if (line_control != dat) begin
                        line_control <= dat; state <= S_MUL1;
                      end
                REG_MCR: if ({3'd0, modem_control} != (dat & 8'h1f)) begin
                        logic [7:0] ms;
                        ms = modem_status;
                        if (loop_c && !dat[4]) ms = set_ln(ms, 8'h00);
                        if (dat[4])
                          ms = set_ln(ms, {dat[3], dat[2], dat[0], dat[1], 4'd0});
                        modem_status <= ms;
                        modem_control <= dat[4:0];
                      end
                REG_SCR: if (has_scratch) scratch_byte <= dat;
                default: ;
              endcase
            end
            CMD_RXIN: begin
              if (rx_full_c) res.refused <= 1'b1;
              else begin
                rx_tail <= nxt(rx_tail, rx_slots);
                state <= S_FILLR;
              end
            end
            CMD_TXOUT: begin
              if (tx_empty_c) res.refused <= 1'b1;
              else state <= S_TXD;
            end
            CMD_TICK: begin
              if (pacing_active) begin
                tick_tx <= 1'b1;
                if (rx_time_left != 0) begin
                  if ({16'd0, tck} < rx_time_left)
                    rx_time_left <= rx_time_left - {16'd0, tck};
                  else begin
                    rx_time_left <= '0;
                    rx_burst_left <= read_burst_max;
                    state <= S_FILLR;
                  end
                end
                if (state != S_FILLR && !({16'd0, tck} >= rx_time_left && rx_time_left != 0))
                  state <= S_TICKT;
              end
            end
            CMD_MODEM: begin
              if (!loop_c) modem_status <= set_ln(modem_status, {lines, 4'd0});
            end
            default: ;
          endcase
        end
        S_FILLR: state <= S_FILLD;  // ring read in flight
        S_FILLD: begin
          if (can_fill) begin
            rx_holding <= rx_rd;
            rx_head <= nxt(rx_head, rx_slots);
            rx_burst_left <= rx_burst_left - 8'd1;
            if (rx_time_left == 0) begin
              pacing_active <= 1'b1; rx_time_left <= char_time;
            end
            line_status <= line_status | LSR_DR;
          end
          state <= tick_tx ? S_TICKT : S_IRQ;
        end
        S_TICKT: begin
          tick_tx <= 1'b0;
          state <= S_IRQ;
          if (tx_time_left != 0) begin
            if ({16'd0, tck} < tx_time_left) begin
              tx_time_left <= tx_time_left - {16'd0, tck};
              pacing_active <= rx_time_left != 0 || tx_time_left != 0;
            end else begin
              tx_time_left <= '0;
              tx_burst_left <= write_burst_max;
              state <= S_DRAIN;
            end
          end else begin
            pacing_active <= rx_time_left != 0;
          end
        end
        S_DRAIN: begin
          state <= S_IRQ;
          if (tx_burst_left != 8'd0) begin
            if (line_status[5]) line_status <= line_status | LSR_TEMT;
            else if (loop_c || !tx_full_c) begin
              if (loop_c && !rx_full_c) rx_tail <= nxt(rx_tail, rx_slots);
              if (!loop_c) tx_tail <= nxt(tx_tail, tx_slots);
              tx_burst_left <= tx_burst_left - 8'd1;
              if (tx_time_left == 0) begin
                pacing_active <= 1'b1; tx_time_left <= char_time;
              end
              line_status <= (line_status & ~LSR_TEMT) | LSR_THRE;
              tx_empty_acked <= 1'b0;
              if (loop_c) state <= S_FILLR;
            end
          end
        end
        S_TXD: begin
          state <= S_OUT;
          res.tx_byte <= tx_rd;
          tx_head <= nxt(tx_head, tx_slots);
        end
        S_MUL1: begin
          mul_p <= {24'd0, bit_clock_divider} * {28'd0, char_bits};
          mul_a <= baud_divisor;
          state <= S_MUL2;
        end
        S_MUL2: begin
          char_time <= (mul_a > 16'd1) ? {16'd0, mul_p[15:0]} * {16'd0, mul_a} : mul_p;
          state <= S_IRQ;
        end
        S_IRQ: begin
          // tick path: pacing flag from final counters
          if (cmd == CMD_TICK && pacing_active)
            pacing_active <= rx_time_left != 0 || tx_time_left != 0;
          if (int_enable[0] && line_status[0]) begin
            int_ident <= IIR_RDA; irq_level <= 1'b1;
          end else if (int_enable[1] && line_status[5] && !tx_empty_acked) begin
            int_ident <= IIR_THRE; irq_level <= 1'b1;
          end else begin
            int_ident <= IIR_NONE; irq_level <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result is held stable until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res)) else $error("result moved");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept during result");
  assert property (@(posedge clk) disable iff (rst)
    irq_level == (int_ident != IIR_NONE) || state != S_IDLE) else $error("irq mismatch");
endmodule

// ----- sv/u8250_ram.sv -----
// ----------------------------------------------------------------------------
// u8250_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u8250_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- bench/uart_8250_register_model_core_tb.sv -----
// ----------------------------------------------------------------------------
// uart_8250_register_model_core_tb
// Drives bus, line, tick and modem commands into the UART register core.
// A local model of the register file and rings predicts every result, and
// the results are compared field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module uart_8250_register_model_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8250_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] txb;
    logic       refused;
    logic       irq;
    logic       dtr;
    logic       rts;
  } uart_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = '0;
  logic [2:0]  reg_addr = '0;
  logic [7:0]  data_in = '0;
  logic [15:0] tick_count = '0;
  logic        dsr_in = 1'b0, cts_in = 1'b0, dcd_in = 1'b0, ri_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data, tx_byte;
  logic        refused, irq_line, dtr_out, rts_out;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  uart_8250_register_model_core u_top (.*);

  // Model state
  logic [7:0]  m_rxr [DEPTH];
  logic [7:0]  m_txr [DEPTH];
  int unsigned m_rxh, m_rxt, m_txh, m_txt;
  logic [7:0]  m_rxhold, m_txhold, m_ier, m_iir, m_lcr, m_lsr, m_mcr, m_msr, m_scr;
  bit          m_ackd, m_pacing, m_irq;
  logic [31:0] m_rxleft, m_txleft, m_ctime;
  logic [7:0]  m_rxburst, m_txburst;
  logic [15:0] m_div;
  bit          c_scratch;
  logic [7:0]  c_bitdiv, c_rmax, c_wmax;
  int unsigned c_rslots, c_tslots;

  uart_result_t expected_results[$];
  int          fail_count = 0;
  int          cycles = 0;
  int          send_idle = 0, recv_idle = 0;

  function automatic int unsigned ring_adv(int unsigned i, int unsigned n);
    return (i + 1 < n) ? i + 1 : 0;
  endfunction

  function automatic int unsigned slot_clamp(int unsigned v);
    if (v < 1) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  function automatic bit rx_enqueue(logic [7:0] v);
    int unsigned t;
    t = ring_adv(m_rxt, c_rslots);
    if (t == m_rxh) return 0;
    m_rxr[m_rxt] = v;
    m_rxt = t;
    return 1;
  endfunction

  function automatic bit tx_enqueue(logic [7:0] v);
    int unsigned t;
    t = ring_adv(m_txt, c_tslots);
    if (t == m_txh) return 0;
    m_txr[m_txt] = v;
    m_txt = t;
    return 1;
  endfunction

  function automatic void eval_irq();
    m_iir = IIR_NONE;
    if (m_ier[0] && (m_lsr & LSR_DR)) m_iir = IIR_RDA;
    else if (m_ier[1] && (m_lsr & LSR_THRE) && !m_ackd) m_iir = IIR_THRE;
    m_irq = !m_iir[0];
  endfunction

  function automatic void eval_char_time();
    logic [31:0] v;
    v = 32'd6 + m_lcr[1:0] + (m_lcr[2] ? 32'd2 : 32'd1);
    v = v * c_bitdiv;
    if (m_div > 1) v = v * m_div;
    m_ctime = v;
  endfunction

  function automatic void rx_fill();
    if (m_rxburst == 0 || (m_lsr & LSR_DR) || m_rxh == m_rxt) return;
    m_rxhold = m_rxr[m_rxh];
    m_rxh = ring_adv(m_rxh, c_rslots);
    m_rxburst--;
    if (m_rxleft == 0) begin
      m_pacing = 1;
      m_rxleft = m_ctime;
    end
    m_lsr |= LSR_DR;
    eval_irq();
  endfunction

  function automatic void tx_drain();
    bit loop;
    loop = m_mcr[4];
    if (m_txburst == 0) return;
    if (m_lsr & LSR_THRE) begin
      m_lsr |= LSR_TEMT;
      return;
    end
    if (loop) void'(rx_enqueue(m_txhold));
    else if (!tx_enqueue(m_txhold)) return;
    m_txburst--;
    if (m_txleft == 0) begin
      m_pacing = 1;
      m_txleft = m_ctime;
    end
    m_lsr = (m_lsr & ~LSR_TEMT) | LSR_THRE;
    m_ackd = 0;
    if (loop) rx_fill();
    eval_irq();
  endfunction

  function automatic void apply_lines(logic [7:0] lines);
    logic [7:0] old, now, chg;
    old = m_msr;
    now = (old & 8'h0f) | (lines & 8'hf0);
    chg = (old ^ now) & ~(now & 8'h40) & 8'hf0;
    m_msr = now | (chg >> 4);
  endfunction

  function automatic logic [7:0] loop_lines(logic [7:0] mc);
    return {mc[3], mc[2], mc[0], mc[1], 4'h0};
  endfunction

  function automatic void mcr_write(logic [7:0] v);
    logic [7:0] nv;
    nv = v & 8'h1f;
    if (m_mcr == nv) return;
    if (m_mcr[4] && !nv[4]) apply_lines(8'h00);
    m_mcr = nv;
    if (nv[4]) apply_lines(loop_lines(nv));
  endfunction

  function automatic logic [7:0] reg_read(logic [2:0] a);
    logic [7:0] v;
    bit dlab;
    dlab = m_lcr[7];
    case (a)
      REG_DATA: begin
        if (dlab) return m_div[7:0];
        v = m_rxhold;
        m_lsr &= ~LSR_DR;
        eval_irq();
        rx_fill();
        return v;
      end
      REG_IER: return dlab ? m_div[15:8] : m_ier;
      REG_IIR: begin
        v = m_iir;
        if (v == IIR_THRE) begin
          m_ackd = 1;
          eval_irq();
        end
        return v;
      end
      REG_LCR: return m_lcr;
      REG_MCR: return m_mcr;
      REG_LSR: return m_lsr;
      REG_MSR: begin
        v = m_msr;
        m_msr &= 8'hf0;
        return v;
      end
      default: return c_scratch ? m_scr : 8'hff;
    endcase
  endfunction

  function automatic void reg_write(logic [2:0] a, logic [7:0] v);
    case (a)
      REG_DATA: begin
        if (m_lcr[7]) begin
          m_div[7:0] = v;
          eval_char_time();
        end else begin
          m_txhold = v;
          m_lsr &= ~LSR_THRE;
          eval_irq();
          tx_drain();
        end
      end
      REG_IER: begin
        if (m_lcr[7]) begin
          m_div[15:8] = v;
          eval_char_time();
        end else begin
          m_ier = v & 8'h0f;
          m_ackd = 0;
          eval_irq();
        end
      end
      REG_LCR: if (m_lcr != v) begin
        m_lcr = v;
        eval_char_time();
      end
      REG_MCR: mcr_write(v);
      REG_SCR: if (c_scratch) m_scr = v;
      default: ;
    endcase
  endfunction

  function automatic void pace_tick(logic [31:0] n);
    if (!m_pacing) return;
    if (m_rxleft > 0) begin
      if (n < m_rxleft) m_rxleft -= n;
      else begin
        m_rxleft = 0;
        m_rxburst = c_rmax;
        rx_fill();
      end
    end
    if (m_txleft > 0) begin
      if (n < m_txleft) m_txleft -= n;
      else begin
        m_txleft = 0;
        m_txburst = c_wmax;
        tx_drain();
      end
    end
    m_pacing = (m_rxleft > 0) || (m_txleft > 0);
  endfunction

  function automatic void uart_reset_state();
    m_rxh = 0; m_rxt = 0; m_txh = 0; m_txt = 0;
    m_rxhold = 0; m_txhold = 0; m_ier = 0; m_iir = IIR_NONE; m_lcr = 0;
    m_lsr = 8'h60; m_mcr = 0; m_msr = 0; m_scr = 0;
    m_ackd = 1; m_pacing = 0; m_irq = 0;
    m_rxleft = 0; m_txleft = 0; m_ctime = CHAR_TIME_RST;
    m_rxburst = 1; m_txburst = 1; m_div = 0;
    c_scratch = 1; c_bitdiv = 10; c_rmax = 1; c_wmax = 1;
    c_rslots = 9; c_tslots = 9;
  endfunction

  function automatic uart_result_t uart_predict(logic [2:0] cmd, logic [2:0] a,
      logic [7:0] d, logic [15:0] tk, logic dsr, logic cts, logic dcd, logic ri);
    uart_result_t r;
    r = '0;
    case (cmd)
      CMD_READ:  r.rd = reg_read(a);
      CMD_WRITE: reg_write(a, d);
      CMD_RXIN:  if (rx_enqueue(d)) rx_fill(); else r.refused = 1;
      CMD_TXOUT: begin
        if (m_txh == m_txt) r.refused = 1;
        else begin
          r.txb = m_txr[m_txh];
          m_txh = ring_adv(m_txh, c_tslots);
        end
      end
      CMD_TICK:  pace_tick({16'h0, tk});
      CMD_MODEM: if (!m_mcr[4]) apply_lines({dcd, ri, dsr, cts, 4'h0});
      default: ;
    endcase
    r.irq = m_irq;
    r.dtr = m_mcr[0];
    r.rts = m_mcr[1];
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $realtime);
      $display("FAIL uart_8250_register_model_core");
      $finish;
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    uart_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{read_data, tx_byte, refused, irq_line, dtr_out, rts_out};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected rd=%h tx=%h ref=%b irq=%b dtr=%b rts=%b",
                   $realtime, want.rd, want.txb, want.refused, want.irq, want.dtr,
                   want.rts);
          $display("%0t            actual rd=%h tx=%h ref=%b irq=%b dtr=%b rts=%b",
                   $realtime, got.rd, got.txb, got.refused, got.irq, got.dtr, got.rts);
          fail_count++;
        end
      end
    end
  end

  // Transfer one command, predicting its result at acceptance
  task automatic send_cmd(logic [2:0] cmd, logic [2:0] a, logic [7:0] d,
      logic [15:0] tk = '0, logic [3:0] lines = '0);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    command <= cmd; reg_addr <= a; data_in <= d; tick_count <= tk;
    {ri_in, dcd_in, dsr_in, cts_in} <= lines;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(uart_predict(cmd, a, d, tk, lines[1], lines[0],
                                            lines[2], lines[3]));
    @(negedge clk);
  endtask

  // Drop valid, then wait for all results plus the block's longest latency
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [7:0] v);
    cfg_index <= idx; cfg_data <= v; cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_SCRATCH: c_scratch = v[0];
      CFG_BITDIV:  c_bitdiv = v;
      CFG_RBURST:  c_rmax = v;
      CFG_WBURST:  c_wmax = v;
      CFG_RSLOTS: begin c_rslots = slot_clamp(v[4:0]); m_rxh = 0; m_rxt = 0; end
      CFG_TSLOTS: begin c_tslots = slot_clamp(v[4:0]); m_txh = 0; m_txt = 0; end
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_cmd(CMD_WRITE, REG_IER, 8'hff);       // all interrupts on
    send_cmd(CMD_WRITE, REG_DATA, 8'ha5);      // transmit into ring
    send_cmd(CMD_READ, REG_IIR, '0);           // ack transmit-empty
    send_cmd(CMD_TXOUT, REG_DATA, '0);
    send_cmd(CMD_TXOUT, REG_DATA, '0);         // empty ring refuses
    send_cmd(CMD_RXIN, REG_DATA, 8'h00);
    send_cmd(CMD_RXIN, REG_DATA, 8'hff);
    send_cmd(CMD_READ, REG_DATA, '0);
    send_cmd(CMD_TICK, REG_DATA, '0, 16'hffff);
    send_cmd(CMD_READ, REG_DATA, '0);
    send_cmd(CMD_WRITE, REG_LCR, 8'h83);       // DLAB set
    send_cmd(CMD_WRITE, REG_DATA, 8'hff);
    send_cmd(CMD_WRITE, REG_IER, 8'hff);
    send_cmd(CMD_READ, REG_DATA, '0);
    send_cmd(CMD_READ, REG_IER, '0);
    send_cmd(CMD_WRITE, REG_LCR, 8'h07);
    send_cmd(CMD_MODEM, REG_DATA, '0, '0, 4'hf);
    send_cmd(CMD_MODEM, REG_DATA, '0, '0, 4'h0);  // ring indicator falls
    send_cmd(CMD_READ, REG_MSR, '0);
    send_cmd(CMD_WRITE, REG_MCR, 8'h1f);       // loopback
    send_cmd(CMD_WRITE, REG_DATA, 8'h3c);
    send_cmd(CMD_MODEM, REG_DATA, '0, '0, 4'h5);  // ignored in loopback
    send_cmd(CMD_WRITE, REG_MCR, 8'h00);       // leave loopback
    send_cmd(CMD_READ, REG_MSR, '0);
    send_cmd(CMD_RSV6, REG_SCR, 8'h55);
    send_cmd(CMD_RSV7, REG_LSR, 8'haa);
    send_cmd(CMD_WRITE, REG_SCR, 8'h99);
    send_cmd(CMD_READ, REG_SCR, '0);
  endtask

  // Random commands, weighted toward bus reads and writes
  task automatic test_random(int n);
    int k;
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 25) cmd = CMD_READ;
      else if (k < 50) cmd = CMD_WRITE;
      else if (k < 65) cmd = CMD_RXIN;
      else if (k < 77) cmd = CMD_TXOUT;
      else if (k < 92) cmd = CMD_TICK;
      else if (k < 98) cmd = CMD_MODEM;
      else cmd = ($urandom_range(1) != 0) ? CMD_RSV7 : CMD_RSV6;
      send_cmd(cmd, 3'($urandom_range(7)), 8'($urandom_range(255)),
               16'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                            : $urandom_range(300)),
               4'($urandom_range(15)));
    end
  endtask

  task automatic test_configs();
    cfg_write(CFG_SCRATCH, 8'd0);
    cfg_write(CFG_BITDIV, 8'd0);
    cfg_write(CFG_RBURST, 8'd255);
    cfg_write(CFG_WBURST, 8'd0);
    cfg_write(CFG_RSLOTS, 8'd1);
    cfg_write(CFG_TSLOTS, 8'd16);
    test_random(220);
    drain_wait();
    cfg_write(CFG_SCRATCH, 8'd1);
    cfg_write(CFG_BITDIV, 8'd255);
    cfg_write(CFG_RBURST, 8'd0);
    cfg_write(CFG_WBURST, 8'd255);
    cfg_write(CFG_RSLOTS, 8'd31);
    cfg_write(CFG_TSLOTS, 8'd0);
    test_random(220);
    drain_wait();
    cfg_write(CFG_BITDIV, 8'd1);
    cfg_write(CFG_RBURST, 8'd3);
    cfg_write(CFG_WBURST, 8'd2);
    cfg_write(CFG_RSLOTS, 8'd4);
    cfg_write(CFG_TSLOTS, 8'd3);
    test_random(200);
    drain_wait();
  endtask

  initial begin
    uart_reset_state();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    send_idle = 7; recv_idle = 52;
    test_directed();
    test_random(300);
    drain_wait();                              // sender holds off here
    send_idle = 52; recv_idle = 7;
    test_configs();
    send_idle = 0; recv_idle = 0;
    test_random(330);
    drain_wait();
    if (fail_count == 0) $display("PASS uart_8250_register_model_core");
    else $display("FAIL uart_8250_register_model_core");
    $finish;
  end
endmodule
